// ===== hdl/tcu_pkg.sv =====
// Shared constants, types and helpers of the Taylor-series cosine unit.
// Used by the channel interfaces, the rounding multiplier and the top level.
// Depends on nothing else.
`default_nettype none

package tcu_pkg;

  // Field formats.
  localparam int ANGLE_W          = 32;
  localparam int ANGLE_FRAC_BITS  = 24;
  localparam int RESULT_FRAC_BITS = 16;
  localparam int COS_W            = RESULT_FRAC_BITS + 2;
  localparam int POWER_W          = 4;
  localparam logic [POWER_W-1:0] POWER_RESET = POWER_W'(10);

  // Working format of the series: Q52 in every case.
  localparam int WORK_BITS = 52;

  // Range reduction: the angle is moved up by RED_SHIFT bits and reduced by
  // one conditional subtraction of a shifted 2*pi per stage.
  localparam int RED_SHIFT    = 28;
  localparam int RED_W        = 61;
  localparam int FOLD_SHIFT   = ANGLE_W - ANGLE_FRAC_BITS;
  localparam int REDUCE_STEPS = ANGLE_W - ANGLE_FRAC_BITS - 1;
  localparam logic [63:0] TWO_PI_Q60 = 64'h6487ED5110B4611A;
  localparam logic [RED_W-1:0] TWO_PI_RED = RED_W'(TWO_PI_Q60 >> FOLD_SHIFT);

  // Rounding of the folded angle from Q60 into the working format.
  localparam int X_SHIFT = 8;
  localparam logic [63:0] X_ROUND = 64'd1 << (X_SHIFT - 1);

  // Rounding multiplier: operands are split into two halves.
  localparam int MUL_W  = 58;
  localparam int HALF_W = MUL_W / 2;
  localparam int PROD_W = 2 * MUL_W;
  localparam logic [2*HALF_W:0] MUL_ROUND = (2*HALF_W+1)'(64'd1 << (WORK_BITS - 1));

  // Signed accumulator of the Horner evaluation.
  localparam int ACC_W = MUL_W + 1;

  // Series terms: coefficients round(2^52 / (2k)!) for k = 1 .. TERM_COUNT.
  localparam int TERM_COUNT = 6;
  localparam int TERM_IDX_W = 3;
  localparam logic [63:0] ONE64 = 64'd1 << WORK_BITS;
  localparam logic signed [ACC_W-1:0] ONE     = ACC_W'(ONE64);
  localparam logic signed [ACC_W-1:0] NEG_ONE = -ONE;
  localparam logic signed [ACC_W-1:0] COEF [1:TERM_COUNT] = '{
    ACC_W'((ONE64 + 64'd1) / 64'd2),
    ACC_W'((ONE64 + 64'd12) / 64'd24),
    ACC_W'((ONE64 + 64'd360) / 64'd720),
    ACC_W'((ONE64 + 64'd20160) / 64'd40320),
    ACC_W'((ONE64 + 64'd1814400) / 64'd3628800),
    ACC_W'((ONE64 + 64'd239500800) / 64'd479001600)
  };

  // Final rounding into the result format, ties towards plus infinity.
  localparam int ROUND_SH = WORK_BITS - RESULT_FRAC_BITS;
  localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(64'd1 << (ROUND_SH - 1));

  typedef logic [ANGLE_W-1:0]        tcu_angle_t;
  typedef logic signed [COS_W-1:0]   tcu_cos_t;
  typedef logic [POWER_W-1:0]        tcu_power_t;
  typedef logic [TERM_IDX_W-1:0]     tcu_idx_t;
  typedef logic [RED_W-1:0]          tcu_red_t;
  typedef logic [63:0]               tcu_wide_t;
  typedef logic [MUL_W-1:0]          tcu_mag_t;
  typedef logic [2*HALF_W-1:0]       tcu_pp_t;
  typedef logic [2*HALF_W:0]         tcu_part_t;
  typedef logic [PROD_W:0]           tcu_sum_t;
  typedef logic signed [ACC_W-1:0]   tcu_acc_t;

  // A product of the Horner chain in sign and magnitude form. A skipped term
  // is marked as zero.
  typedef struct packed {
    logic     zero;
    logic     neg;
    tcu_mag_t mag;
  } tcu_term_t;

  // What travels alongside an operand through the multiplier.
  typedef struct packed {
    logic     skip;
    logic     sneg;
    tcu_mag_t xsq;
  } tcu_side_t;

  // Signed value of a product term.
  function automatic tcu_acc_t term_value(input tcu_term_t t);
    tcu_acc_t v;
    v = $signed({1'b0, t.mag});
    if (t.zero) begin
      term_value = '0;
    end else if (t.neg) begin
      term_value = -v;
    end else begin
      term_value = v;
    end
  endfunction

endpackage

`default_nettype wire

// ===== hdl/tcu_if.sv =====
// Channel interfaces of the cosine unit: angle input, cosine result and
// configuration write. Each carries valid, ready and its payload.
// Depends on tcu_pkg.
`default_nettype none

interface tcu_angle_if;
  logic                valid;
  logic                ready;
  tcu_pkg::tcu_angle_t angle;

  modport source (output valid, output angle, input ready);
  modport sink (input valid, input angle, output ready);
endinterface

interface tcu_cosine_if;
  logic              valid;
  logic              ready;
  tcu_pkg::tcu_cos_t cosine;

  modport source (output valid, output cosine, input ready);
  modport sink (input valid, input cosine, output ready);
endinterface

interface tcu_cfg_if;
  logic                valid;
  logic                ready;
  tcu_pkg::tcu_power_t highest_power;

  modport source (output valid, output highest_power, input ready);
  modport sink (input valid, input highest_power, output ready);
endinterface

`default_nettype wire

// ===== hdl/taylor_cosine_unit_top.sv =====
// Taylor-series cosine unit. Each input transaction carries an angle in
// radians (unsigned, 24 fraction bits) and yields exactly one result
// transaction with its cosine (signed, 16 fraction bits, saturated to -1..1),
// in order. The unit is a single pipeline that takes one transaction per
// cycle while the output skid entry is empty. It is made up of the
// input register, seven range-reduction stages (one compare and subtract of
// a shifted 2*pi each), the fold stage, the three-stage squaring multiplier,
// six Horner steps of five stages each (add, magnitude, three-stage
// multiplier), two stages of saturation and rounding, and the output
// register. A two-entry output buffer lets the pipeline keep taking work
// while a result waits. The highest_power register may be written only while
// no transaction is in flight; it resets to 10.
// Depends on tcu_pkg, tcu_if and tcu_rmul.
`default_nettype none

module taylor_cosine_unit_top (
  input  logic          clk,
  input  logic          rst_n,
  tcu_angle_if.sink     in_chan,
  tcu_cosine_if.source  out_chan,
  tcu_cfg_if.sink       cfg_chan
);

  logic                en;
  tcu_pkg::tcu_power_t power_r;
  tcu_pkg::tcu_idx_t   terms;

  // Pipeline advances whenever the output buffer has room for one more result.
  logic skid_v_r;
  assign en            = !skid_v_r;
  assign in_chan.ready = en;

  // Configuration register.
  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      power_r <= tcu_pkg::POWER_RESET;
    end else if (cfg_chan.valid && cfg_chan.ready) begin
      power_r <= cfg_chan.highest_power;
    end
  end

  // Number of series terms: half the power, at most six.
  always_comb begin
    if (tcu_pkg::tcu_idx_t'(power_r >> 1) > tcu_pkg::tcu_idx_t'(tcu_pkg::TERM_COUNT)) begin
      terms = tcu_pkg::tcu_idx_t'(tcu_pkg::TERM_COUNT);
    end else begin
      terms = tcu_pkg::tcu_idx_t'(power_r >> 1);
    end
  end

  // Input register and range reduction modulo 2*pi.
  logic              red_v_r [tcu_pkg::REDUCE_STEPS+1];
  tcu_pkg::tcu_red_t red_r   [tcu_pkg::REDUCE_STEPS+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      red_v_r[0] <= 1'b0;
    end else if (en) begin
      red_v_r[0] <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      red_r[0] <= tcu_pkg::tcu_red_t'(in_chan.angle) << tcu_pkg::RED_SHIFT;
    end
  end

  for (genvar k = 0; k < tcu_pkg::REDUCE_STEPS; k++) begin : g_red
    localparam tcu_pkg::tcu_red_t STEP_MOD =
      tcu_pkg::TWO_PI_RED << (tcu_pkg::REDUCE_STEPS - 1 - k);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        red_v_r[k+1] <= 1'b0;
      end else if (en) begin
        red_v_r[k+1] <= red_v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (red_r[k] >= STEP_MOD) begin
          red_r[k+1] <= red_r[k] - STEP_MOD;
        end else begin
          red_r[k+1] <= red_r[k];
        end
      end
    end
  end

  // Fold into 0..pi and round into the working format.
  tcu_pkg::tcu_red_t  rem, rem_alt, rem_fold;
  tcu_pkg::tcu_wide_t x60, xw;
  logic               x_v_r;
  tcu_pkg::tcu_mag_t  x_r;

  assign rem      = red_r[tcu_pkg::REDUCE_STEPS];
  assign rem_alt  = tcu_pkg::TWO_PI_RED - rem;
  assign rem_fold = (rem > rem_alt) ? rem_alt : rem;
  assign x60      = tcu_pkg::tcu_wide_t'(rem_fold) << tcu_pkg::FOLD_SHIFT;
  assign xw       = (x60 + tcu_pkg::X_ROUND) >> tcu_pkg::X_SHIFT;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_v_r <= 1'b0;
    end else if (en) begin
      x_v_r <= red_v_r[tcu_pkg::REDUCE_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r <= tcu_pkg::tcu_mag_t'(xw);
    end
  end

  // Square of the folded angle; its negation is the Horner variable.
  tcu_pkg::tcu_mag_t sq_mag;
  logic              sq_v1_r, sq_v2_r, sq_v3_r;

  tcu_rmul u_square (
    .clk  (clk),
    .en   (en),
    .a    (x_r),
    .b    (x_r),
    .prod (sq_mag)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_v1_r <= 1'b0;
      sq_v2_r <= 1'b0;
      sq_v3_r <= 1'b0;
    end else if (en) begin
      sq_v1_r <= x_v_r;
      sq_v2_r <= sq_v1_r;
      sq_v3_r <= sq_v2_r;
    end
  end

  // Horner chain, highest term first. Terms above the configured count are
  // skipped and hand on a zero product.
  logic               step_v   [tcu_pkg::TERM_COUNT+1];
  tcu_pkg::tcu_mag_t  step_xsq [tcu_pkg::TERM_COUNT];
  tcu_pkg::tcu_term_t step_acc [tcu_pkg::TERM_COUNT+1];

  assign step_v[0]   = sq_v3_r;
  assign step_xsq[0] = sq_mag;
  assign step_acc[0] = '{zero: 1'b1, neg: 1'b0, mag: '0};

  for (genvar i = 0; i < tcu_pkg::TERM_COUNT; i++) begin : g_term
    logic               a_v_r, a_skip_r;
    tcu_pkg::tcu_acc_t  a_s_r;
    tcu_pkg::tcu_mag_t  a_xsq_r;
    logic               b_v_r;
    tcu_pkg::tcu_side_t b_side_r;
    tcu_pkg::tcu_mag_t  b_smag_r;
    logic               m_v1_r, m_v2_r, m_v3_r;
    tcu_pkg::tcu_side_t m_side1_r, m_side2_r, m_side3_r;
    tcu_pkg::tcu_mag_t  m_prod;

    // Add the coefficient to the product of the step above.
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        a_v_r <= 1'b0;
      end else if (en) begin
        a_v_r <= step_v[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        a_s_r    <= tcu_pkg::COEF[tcu_pkg::TERM_COUNT - i]
                    + tcu_pkg::term_value(step_acc[i]);
        a_skip_r <= tcu_pkg::tcu_idx_t'(tcu_pkg::TERM_COUNT - i) > terms;
        a_xsq_r  <= step_xsq[i];
      end
    end

    // Split the sum into sign and magnitude.
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        b_v_r <= 1'b0;
      end else if (en) begin
        b_v_r <= a_v_r;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        b_side_r.skip <= a_skip_r;
        b_side_r.sneg <= a_s_r[tcu_pkg::ACC_W-1];
        b_side_r.xsq  <= a_xsq_r;
        if (a_s_r[tcu_pkg::ACC_W-1]) begin
          b_smag_r <= tcu_pkg::tcu_mag_t'(-a_s_r);
        end else begin
          b_smag_r <= tcu_pkg::tcu_mag_t'(a_s_r);
        end
      end
    end

    // Multiply by the square; the sign and the square ride alongside.
    tcu_rmul u_mul (
      .clk  (clk),
      .en   (en),
      .a    (b_smag_r),
      .b    (b_side_r.xsq),
      .prod (m_prod)
    );

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        m_v1_r <= 1'b0;
        m_v2_r <= 1'b0;
        m_v3_r <= 1'b0;
      end else if (en) begin
        m_v1_r <= b_v_r;
        m_v2_r <= m_v1_r;
        m_v3_r <= m_v2_r;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        m_side1_r <= b_side_r;
        m_side2_r <= m_side1_r;
        m_side3_r <= m_side2_r;
      end
    end

    // The Horner variable is the negated square, so the product sign flips.
    assign step_v[i+1]   = m_v3_r;
    assign step_acc[i+1] = '{zero: m_side3_r.skip, neg: !m_side3_r.sneg, mag: m_prod};

    if (i < tcu_pkg::TERM_COUNT - 1) begin : g_xsq
      assign step_xsq[i+1] = m_side3_r.xsq;
    end
  end

  // Add one and saturate to the range -1 .. 1.
  tcu_pkg::tcu_acc_t cv, cv_r;
  logic              cv_v_r;

  assign cv = tcu_pkg::ONE + tcu_pkg::term_value(step_acc[tcu_pkg::TERM_COUNT]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cv_v_r <= 1'b0;
    end else if (en) begin
      cv_v_r <= step_v[tcu_pkg::TERM_COUNT];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (cv > tcu_pkg::ONE) begin
        cv_r <= tcu_pkg::ONE;
      end else if (cv < tcu_pkg::NEG_ONE) begin
        cv_r <= tcu_pkg::NEG_ONE;
      end else begin
        cv_r <= cv;
      end
    end
  end

  // Round into the result format.
  tcu_pkg::tcu_acc_t cv_round;
  logic              pipe_v_r;
  tcu_pkg::tcu_cos_t pipe_cos_r;

  assign cv_round = (cv_r + tcu_pkg::ROUND_HALF) >>> tcu_pkg::ROUND_SH;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pipe_v_r <= 1'b0;
    end else if (en) begin
      pipe_v_r <= cv_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pipe_cos_r <= tcu_pkg::tcu_cos_t'(cv_round);
    end
  end

  // Output register with a skid entry behind it.
  logic              out_v_r, out_free;
  tcu_pkg::tcu_cos_t out_cos_r, skid_cos_r;

  assign out_free = !out_v_r || out_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (out_free) begin
      if (skid_v_r) begin
        out_v_r  <= 1'b1;
        skid_v_r <= 1'b0;
      end else begin
        out_v_r <= pipe_v_r;
      end
    end else if (en && pipe_v_r) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_v_r) begin
        out_cos_r <= skid_cos_r;
      end else begin
        out_cos_r <= pipe_cos_r;
      end
    end else if (en && pipe_v_r) begin
      skid_cos_r <= pipe_cos_r;
    end
  end

  assign out_chan.valid  = out_v_r;
  assign out_chan.cosine = out_cos_r;

endmodule

`default_nettype wire

// ===== hdl/tcu_rmul.sv =====
// Pipelined unsigned multiplier of two working-format magnitudes, rounded to
// nearest with ties away from zero. Three register stages. Depends on tcu_pkg.
`default_nettype none

module tcu_rmul (
  input  logic              clk,
  input  logic              en,
  input  tcu_pkg::tcu_mag_t a,
  input  tcu_pkg::tcu_mag_t b,
  output tcu_pkg::tcu_mag_t prod
);

  tcu_pkg::tcu_pp_t   pp00_r, pp01_r, pp10_r, pp11_r;
  tcu_pkg::tcu_part_t mid_r, lo_r;
  tcu_pkg::tcu_pp_t   hi_r;
  tcu_pkg::tcu_mag_t  prod_r;
  tcu_pkg::tcu_sum_t  sum;

  // Four half-width partial products.
  always_ff @(posedge clk) begin
    if (en) begin
      pp00_r <= tcu_pkg::tcu_pp_t'(a[tcu_pkg::HALF_W-1:0])
                * tcu_pkg::tcu_pp_t'(b[tcu_pkg::HALF_W-1:0]);
      pp01_r <= tcu_pkg::tcu_pp_t'(a[tcu_pkg::HALF_W-1:0])
                * tcu_pkg::tcu_pp_t'(b[tcu_pkg::MUL_W-1:tcu_pkg::HALF_W]);
      pp10_r <= tcu_pkg::tcu_pp_t'(a[tcu_pkg::MUL_W-1:tcu_pkg::HALF_W])
                * tcu_pkg::tcu_pp_t'(b[tcu_pkg::HALF_W-1:0]);
      pp11_r <= tcu_pkg::tcu_pp_t'(a[tcu_pkg::MUL_W-1:tcu_pkg::HALF_W])
                * tcu_pkg::tcu_pp_t'(b[tcu_pkg::MUL_W-1:tcu_pkg::HALF_W]);
    end
  end

  // Cross terms are summed and the rounding constant joins the low term.
  always_ff @(posedge clk) begin
    if (en) begin
      mid_r <= tcu_pkg::tcu_part_t'(pp01_r) + tcu_pkg::tcu_part_t'(pp10_r);
      lo_r  <= tcu_pkg::tcu_part_t'(pp00_r) + tcu_pkg::MUL_ROUND;
      hi_r  <= pp11_r;
    end
  end

  // Final alignment; the rounded product is the part above the fraction bits.
  assign sum = (tcu_pkg::tcu_sum_t'(hi_r) << (2 * tcu_pkg::HALF_W))
             + (tcu_pkg::tcu_sum_t'(mid_r) << tcu_pkg::HALF_W)
             + tcu_pkg::tcu_sum_t'(lo_r);

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= sum[tcu_pkg::WORK_BITS +: tcu_pkg::MUL_W];
    end
  end

  assign prod = prod_r;

endmodule

`default_nettype wire
